/* src/bal_pkg.sv */
// Package for the bounded array list engine: sizes, action and status codes,
// request and response payload types. No dependencies.
package bal_pkg;

   localparam int CAPACITY    = 32;
   localparam int MAX_RESULTS = 32;
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int DATA_W      = 32;

   localparam logic [3:0] ACT_PUSH_BACK    = 4'd0;
   localparam logic [3:0] ACT_POP_BACK     = 4'd1;
   localparam logic [3:0] ACT_PUSH_FRONT   = 4'd2;
   localparam logic [3:0] ACT_POP_FRONT    = 4'd3;
   localparam logic [3:0] ACT_INSERT       = 4'd4;
   localparam logic [3:0] ACT_ERASE        = 4'd5;
   localparam logic [3:0] ACT_FIND         = 4'd6;
   localparam logic [3:0] ACT_REMOVE_FIRST = 4'd7;
   localparam logic [3:0] ACT_MODIFY       = 4'd8;
   localparam logic [3:0] ACT_SORT_DESC    = 4'd9;
   localparam logic [3:0] ACT_REMOVE_ALL   = 4'd10;
   localparam logic [3:0] ACT_READ_ALL     = 4'd11;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [3:0]         action;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic [4:0]         index;
      logic [5:0]         count;
      logic [2:0]         status;
      logic               last;
   } rsp_type;

endpackage

/* src/bal_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/bounded_array_list_engine.sv */
// Bounded array list engine top level: request decode, list sequencer and
// response register around one element RAM. Depends on bal_pkg and bal_ram.
//
// The list lives in a single 32-entry RAM with registered reads; all work is a
// walk over it, one entry per cycle while the output is not stalled. A request
// that needs no walk (pops at the back, modify, sort of fewer than two entries,
// errors, unused codes) is decoded in S_DEC and has its response registered in
// S_RESP; the engine then returns to S_IDLE to take the next request. Shifts,
// searches, compaction and read-out walk the entries involved. Sort is a bubble
// sort: each pass walks the unsorted entries, and it stops after a pass without
// swaps or after count-1 passes. A stalled response holds the decode of the next
// request, and during read-out a stalled response makes the engine re-read the
// same entry until the output is free. One request is processed at a time; the
// next is taken once its last response has been handed to the output register.
// Read_all emits one response per element, with last on the final one.
module bounded_array_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bal_pkg::rsp_type rsp_data
);
   import bal_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DEC    = 4'd1;
   localparam logic [3:0] S_SHUP   = 4'd2;  // shift up (push and insert), reading down
   localparam logic [3:0] S_SHDN   = 4'd3;  // shift down (pop_front, erase, remove_first), reading up
   localparam logic [3:0] S_FIND   = 4'd4;
   localparam logic [3:0] S_COMP   = 4'd5;  // remove_all compaction
   localparam logic [3:0] S_READ   = 4'd6;
   localparam logic [3:0] S_SORT   = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;
   localparam logic [3:0] S_SHUPW  = 4'd9;  // write of the new value after shift

   logic [3:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;       // read pointer
   logic [CNT_W-1:0]  wptr_ff, wptr_in;     // write pointer / pass limit
   logic              rdv_ff, rdv_in;       // read data valid for entry lastp_ff
   logic [DATA_W-1:0] hold_ff, hold_in;     // sort carry element
   logic              hold_v_ff, hold_v_in;
   logic              swp_ff, swp_in;       // a swap happened this pass
   logic [CNT_W-1:0]  lastp_ff, lastp_in;   // element index of pending read
   logic              ovalid_ff, ovalid_in;
   rsp_type           odata_ff, odata_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   bal_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic out_free;
   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = odata_ff;

   function automatic logic sgt(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      wptr_in   = wptr_ff;
      rdv_in    = 1'b0;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      swp_in    = swp_ff;
      lastp_in  = lastp_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in  = odata_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = req_ff.value;
      rd_addr   = ptr_ff[ADDR_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_RESP;
            if (ovalid_ff && rsp_stall) begin
               state_in = S_DEC;   // output still occupied
            end else begin
               // status / index held in odata_ff fields until the response
               odata_in.element = '0;
               odata_in.index   = '0;
               odata_in.status  = ST_OK;
               odata_in.last    = 1'b1;
               case (req_ff.action)
                  ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        odata_in.status = ST_FULL;
                     end else if (req_ff.action == ACT_INSERT &&
                                  {1'b0, req_ff.position} > 7'(count_ff)) begin
                        odata_in.status = ST_BADPOS;
                     end else begin
                        // wptr = insert position; shift from count-1 down.
                        if (req_ff.action == ACT_PUSH_BACK)
                           wptr_in = count_ff;
                        else if (req_ff.action == ACT_PUSH_FRONT)
                           wptr_in = '0;
                        else
                           wptr_in = CNT_W'(req_ff.position);
                        ptr_in   = count_ff;
                        state_in = S_SHUP;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (count_ff == '0) odata_in.status = ST_EMPTY;
                     else count_in = count_ff - 1'b1;
                  end
                  ACT_POP_FRONT, ACT_ERASE, ACT_MODIFY: begin
                     if (count_ff == '0) begin
                        odata_in.status = ST_EMPTY;
                     end else if (req_ff.action != ACT_POP_FRONT &&
                                  7'(req_ff.position) >= 7'(count_ff)) begin
                        odata_in.status = ST_BADPOS;
                     end else if (req_ff.action == ACT_MODIFY) begin
                        wr_en   = 1'b1;
                        wr_addr = req_ff.position[ADDR_W-1:0];
                     end else begin
                        wptr_in  = (req_ff.action == ACT_ERASE) ?
                                   CNT_W'(req_ff.position) : '0;
                        ptr_in   = ((req_ff.action == ACT_ERASE) ?
                                   CNT_W'(req_ff.position) : '0) + 1'b1;
                        state_in = S_SHDN;
                     end
                  end
                  ACT_FIND, ACT_REMOVE_FIRST: begin
                     ptr_in   = '0;
                     state_in = S_FIND;
                  end
                  ACT_REMOVE_ALL: begin
                     ptr_in   = '0;
                     wptr_in  = '0;
                     state_in = S_COMP;
                  end
                  ACT_READ_ALL: begin
                     if (count_ff == '0) begin
                        odata_in.status = ST_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  ACT_SORT_DESC: begin
                     if (count_ff > CNT_W'(1)) begin
                        ptr_in    = '0;
                        wptr_in   = count_ff;   // pass limit
                        hold_v_in = 1'b0;
                        swp_in    = 1'b0;
                        state_in  = S_SORT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SHUP: begin
            // Read entry ptr-1, write it to ptr next cycle.
            if (rdv_ff) begin
               wr_en   = 1'b1;
               wr_addr = lastp_ff[ADDR_W-1:0] + 1'b1;
               wr_data = rd_data;
            end
            if (ptr_ff > wptr_ff) begin
               rd_addr  = ADDR_W'(ptr_ff - 1'b1);
               lastp_in = ptr_ff - 1'b1;
               ptr_in   = ptr_ff - 1'b1;
               rdv_in   = 1'b1;
            end else begin
               state_in = S_SHUPW;
            end
         end
         S_SHUPW: begin
            wr_en    = 1'b1;
            wr_addr  = wptr_ff[ADDR_W-1:0];
            count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end
         S_SHDN: begin
            // Read entry ptr, write it to ptr-1 next cycle.
            if (rdv_ff) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(lastp_ff - 1'b1);
               wr_data = rd_data;
            end
            if (ptr_ff < count_ff) begin
               rd_addr  = ptr_ff[ADDR_W-1:0];
               lastp_in = ptr_ff;
               ptr_in   = ptr_ff + 1'b1;
               rdv_in   = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end
         end
         S_FIND: begin
            if (rdv_ff && rd_data == req_ff.value) begin
               if (req_ff.action == ACT_FIND) begin
                  odata_in.index = lastp_ff[4:0];
                  state_in       = S_RESP;
               end else begin
                  ptr_in   = lastp_ff + 1'b1;
                  state_in = S_SHDN;
               end
            end else if (ptr_ff < count_ff) begin
               rd_addr  = ptr_ff[ADDR_W-1:0];
               lastp_in = ptr_ff;
               ptr_in   = ptr_ff + 1'b1;
               rdv_in   = 1'b1;
            end else begin
               odata_in.status = ST_NOTFOUND;
               state_in        = S_RESP;
            end
         end
         S_COMP: begin
            // Writes only go to wptr <= read index, so no hazard.
            if (rdv_ff && rd_data != req_ff.value) begin
               wr_en   = 1'b1;
               wr_addr = wptr_ff[ADDR_W-1:0];
               wr_data = rd_data;
               wptr_in = wptr_ff + 1'b1;
            end
            if (ptr_ff < count_ff) begin
               rd_addr = ptr_ff[ADDR_W-1:0];
               ptr_in  = ptr_ff + 1'b1;
               rdv_in  = 1'b1;
            end else begin
               count_in = (rdv_ff && rd_data != req_ff.value) ?
                          wptr_ff + 1'b1 : wptr_ff;
               state_in = S_RESP;
            end
         end
         S_READ: begin
            if (rdv_ff) begin
               if (out_free) begin
                  ovalid_in        = 1'b1;
                  odata_in.element = rd_data;
                  odata_in.index   = lastp_ff[4:0];
                  odata_in.count   = count_ff[5:0];
                  odata_in.status  = ST_OK;
                  odata_in.last    = (lastp_ff + 1'b1 == count_ff) ||
                                     (lastp_ff + 1'b1 == CNT_W'(MAX_RESULTS));
                  if (odata_in.last) begin
                     state_in = S_IDLE;
                  end else begin
                     rd_addr  = ptr_ff[ADDR_W-1:0];
                     lastp_in = ptr_ff;
                     ptr_in   = ptr_ff + 1'b1;
                     rdv_in   = 1'b1;
                  end
               end else begin
                  // Re-read the same entry while the output is blocked.
                  rd_addr = lastp_ff[ADDR_W-1:0];
                  rdv_in  = 1'b1;
               end
            end else begin
               rd_addr  = ptr_ff[ADDR_W-1:0];
               lastp_in = ptr_ff;
               ptr_in   = ptr_ff + 1'b1;
               rdv_in   = 1'b1;
            end
         end
         S_SORT: begin
            // One bubble pass: carry the smaller element upward in hold_ff.
            if (rdv_ff) begin
               if (!hold_v_ff) begin
                  hold_in   = rd_data;
                  hold_v_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(lastp_ff - 1'b1);
                  if (sgt(rd_data, hold_ff)) begin
                     wr_data = rd_data;
                     swp_in  = 1'b1;
                  end else begin
                     wr_data = hold_ff;
                     hold_in = rd_data;
                  end
               end
            end
            if (ptr_ff < wptr_ff) begin
               rd_addr  = ptr_ff[ADDR_W-1:0];
               lastp_in = ptr_ff;
               ptr_in   = ptr_ff + 1'b1;
               rdv_in   = 1'b1;
            end else if (!rdv_ff) begin
               // Pass done: store the carried element at the pass end.
               wr_en     = 1'b1;
               wr_addr   = ADDR_W'(wptr_ff - 1'b1);
               wr_data   = hold_ff;
               hold_v_in = 1'b0;
               swp_in    = 1'b0;
               ptr_in    = '0;
               wptr_in   = wptr_ff - 1'b1;
               if (!swp_ff || wptr_ff <= CNT_W'(2)) state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               ovalid_in      = 1'b1;
               odata_in.count = count_ff[5:0];
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
         rdv_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         swp_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
         rdv_ff    <= rdv_in;
         hold_v_ff <= hold_v_in;
         swp_ff    <= swp_in;
      end
      req_ff   <= req_in;
      ptr_ff   <= ptr_in;
      wptr_ff  <= wptr_in;
      hold_ff  <= hold_in;
      lastp_ff <= lastp_in;
      odata_ff <= odata_in;
   end

endmodule

/* tb/tb_bounded_array_list_engine.sv */
// Testbench for the bounded array list engine: drives random and directed list
// actions, predicts every response with a behavioral list model and compares.
// Depends on bal_pkg and the bounded_array_list_engine RTL.
`timescale 1ns / 100ps

module tb_bounded_array_list_engine;
   import bal_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bounded_array_list_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   logic signed [31:0] list_words[CAPACITY];
   int  list_len = 0;
   int  mismatches = 0;
   int  cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  stim_done = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_type make_rsp(logic signed [31:0] e, int idx, logic [2:0] st,
                                        logic lst);
      rsp_type r;
      r.element = e;
      r.index   = idx[4:0];
      r.count   = list_len[5:0];
      r.status  = st;
      r.last    = lst;
      return r;
   endfunction

   function automatic void list_insert(int pos, logic signed [31:0] v);
      for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
      list_words[pos] = v;
      list_len++;
   endfunction

   function automatic void list_erase(int pos);
      for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
      list_len--;
   endfunction

   function automatic int list_find(logic signed [31:0] v);
      for (int i = 0; i < list_len; i++) if (list_words[i] == v) return i;
      return -1;
   endfunction

   // Applies one request to the list copy and queues the responses it causes.
   function automatic void predict_list_action(req_type rq);
      logic [2:0] st;
      int idx, w, pos;
      logic signed [31:0] t;
      st = ST_OK; idx = 0; pos = rq.position;
      case (rq.action)
         ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
            if (list_len >= CAPACITY) st = ST_FULL;
            else if (rq.action == ACT_INSERT && pos > list_len) st = ST_BADPOS;
            else list_insert(rq.action == ACT_PUSH_BACK ? list_len :
                             rq.action == ACT_PUSH_FRONT ? 0 : pos, rq.value);
         end
         ACT_POP_BACK: if (list_len == 0) st = ST_EMPTY; else list_len--;
         ACT_POP_FRONT: if (list_len == 0) st = ST_EMPTY; else list_erase(0);
         ACT_ERASE, ACT_MODIFY: begin
            if (list_len == 0) st = ST_EMPTY;
            else if (pos >= list_len) st = ST_BADPOS;
            else if (rq.action == ACT_ERASE) list_erase(pos);
            else list_words[pos] = rq.value;
         end
         ACT_FIND: begin
            w = list_find(rq.value);
            if (w < 0) st = ST_NOTFOUND; else idx = w;
         end
         ACT_REMOVE_FIRST: begin
            w = list_find(rq.value);
            if (w < 0) st = ST_NOTFOUND; else list_erase(w);
         end
         ACT_SORT_DESC: begin
            for (int i = 0; i + 1 < list_len; i++)
               for (int j = 1; j < list_len - i; j++)
                  if (list_words[j] > list_words[j-1]) begin
                     t = list_words[j]; list_words[j] = list_words[j-1];
                     list_words[j-1] = t;
                  end
         end
         ACT_REMOVE_ALL: begin
            w = 0;
            for (int i = 0; i < list_len; i++)
               if (list_words[i] != rq.value) begin
                  list_words[w] = list_words[i]; w++;
               end
            list_len = w;
         end
         ACT_READ_ALL: begin
            if (list_len == 0) expected_rsps.push_back(make_rsp(0, 0, ST_EMPTY, 1'b1));
            else for (int i = 0; i < list_len && i < MAX_RESULTS; i++)
               expected_rsps.push_back(make_rsp(list_words[i], i, ST_OK,
                  (i + 1 == list_len || i + 1 == MAX_RESULTS)));
            return;
         end
         default: ;
      endcase
      expected_rsps.push_back(make_rsp(0, idx, st, 1'b1));
   endfunction

   // Driver: the predictor runs at acceptance so the list copy follows DUT order.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_list_action(req_data);
            void'(pending_reqs.pop_front());
            send_gap = pick_gap();
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   // Monitor: compares each accepted response with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   function automatic req_type make_req(logic [3:0] act, int pos, logic signed [31:0] v);
      req_type r;
      r.action = act; r.position = pos[5:0]; r.value = v;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_word();
      // Small value pool makes matches and duplicates common.
      if ($urandom_range(0, 2) != 0) return $signed($urandom_range(0, 7)) - 4;
      case ($urandom_range(0, 3))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         default: return $signed($urandom());
      endcase
   endfunction

   initial begin
      int model_len, act, r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list errors, fill to full, overflow, bad positions.
      pending_reqs.push_back(make_req(ACT_READ_ALL, 0, 0));
      pending_reqs.push_back(make_req(ACT_POP_BACK, 0, 0));
      pending_reqs.push_back(make_req(ACT_POP_FRONT, 0, 0));
      pending_reqs.push_back(make_req(ACT_ERASE, 0, 0));
      pending_reqs.push_back(make_req(ACT_MODIFY, 0, 0));
      pending_reqs.push_back(make_req(ACT_FIND, 0, 5));
      pending_reqs.push_back(make_req(ACT_SORT_DESC, 0, 0));
      pending_reqs.push_back(make_req(ACT_REMOVE_ALL, 0, 5));
      pending_reqs.push_back(make_req(ACT_INSERT, 1, 9));
      pending_reqs.push_back(make_req(ACT_INSERT, 0, 32'sh80000000));
      pending_reqs.push_back(make_req(4'd12, 63, 32'sh7fffffff));
      pending_reqs.push_back(make_req(4'd15, 0, -1));
      for (int i = 0; i < 31; i++)
         pending_reqs.push_back(make_req(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, 0,
                                         (i % 3 == 0) ? 7 : $signed($urandom())));
      pending_reqs.push_back(make_req(ACT_PUSH_BACK, 0, 32'sh7fffffff));
      pending_reqs.push_back(make_req(ACT_PUSH_BACK, 0, 1));
      pending_reqs.push_back(make_req(ACT_INSERT, 0, 1));
      pending_reqs.push_back(make_req(ACT_READ_ALL, 0, 0));
      pending_reqs.push_back(make_req(ACT_SORT_DESC, 0, 0));
      pending_reqs.push_back(make_req(ACT_READ_ALL, 0, 0));
      pending_reqs.push_back(make_req(ACT_ERASE, 32, 0));
      pending_reqs.push_back(make_req(ACT_MODIFY, 31, -1));
      pending_reqs.push_back(make_req(ACT_REMOVE_FIRST, 0, 3));
      pending_reqs.push_back(make_req(ACT_REMOVE_ALL, 0, 7));
      pending_reqs.push_back(make_req(ACT_READ_ALL, 0, 0));
      model_len = 20;  // rough; only used to steer positions toward the valid range and bias the action choice

      // Random: biased so the list wanders over its whole length.
      for (int n = 0; n < 400; n++) begin
         r = $urandom_range(0, 99);
         if (model_len < 4 && r < 50) act = ACT_PUSH_BACK;
         else if (model_len > 28 && r < 30) act = ACT_POP_FRONT;
         else act = $urandom_range(0, 15);
         if (act == ACT_SORT_DESC && $urandom_range(0, 3) != 0) act = ACT_FIND;
         pending_reqs.push_back(make_req(act[3:0],
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                        : $urandom_range(0, model_len + 1),
            rand_word()));
         case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: if (model_len < 32) model_len++;
            ACT_POP_BACK, ACT_POP_FRONT, ACT_ERASE, ACT_REMOVE_FIRST:
               if (model_len > 0) model_len--;
            ACT_REMOVE_ALL: model_len = model_len / 2;
            default: ;
         endcase
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("** bounded_array_list_engine: PASSED **");
      else
         $display("** bounded_array_list_engine: FAILED **");
      $finish;
   end

   initial begin
      wait (cycles >= 5000000);
      $display("** bounded_array_list_engine: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
src/bal_pkg.sv
src/bal_ram.sv
src/bounded_array_list_engine.sv
tb/tb_bounded_array_list_engine.sv
